@@ design/jts_pkg.sv @@
package jts_pkg;

  // Scanner modes
  typedef enum logic [2:0] {
    SCAN_IDLE   = 3'd0,
    SCAN_NULL   = 3'd1,
    SCAN_TRUE   = 3'd2,
    SCAN_FALSE  = 3'd3,
    SCAN_STRING = 3'd4
  } scan_mode_t;

  // Token kinds
  localparam logic [3:0] K_COMMA    = 4'd0;
  localparam logic [3:0] K_COLON    = 4'd1;
  localparam logic [3:0] K_LBRACK   = 4'd2;
  localparam logic [3:0] K_RBRACK   = 4'd3;
  localparam logic [3:0] K_LBRACE   = 4'd4;
  localparam logic [3:0] K_RBRACE   = 4'd5;
  localparam logic [3:0] K_NULL     = 4'd6;
  localparam logic [3:0] K_TRUE     = 4'd7;
  localparam logic [3:0] K_FALSE    = 4'd8;
  localparam logic [3:0] K_SCHAR    = 4'd9;
  localparam logic [3:0] K_SEND     = 4'd10;
  localparam logic [3:0] K_ERROR    = 4'd11;
  localparam logic [3:0] K_FLUSH_OK = 4'd12;

  // Item mode codes
  localparam logic MODE_CHAR  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // String length counter saturates here
  localparam logic [15:0] MAX_STRING_LEN = 16'hFFFF;

  // Code points of interest
  localparam logic [20:0] CH_TAB    = 21'h09;
  localparam logic [20:0] CH_LF     = 21'h0A;
  localparam logic [20:0] CH_CR     = 21'h0D;
  localparam logic [20:0] CH_SPACE  = 21'h20;
  localparam logic [20:0] CH_QUOTE  = 21'h22;
  localparam logic [20:0] CH_COMMA  = 21'h2C;
  localparam logic [20:0] CH_COLON  = 21'h3A;
  localparam logic [20:0] CH_LBRACK = 21'h5B;
  localparam logic [20:0] CH_RBRACK = 21'h5D;
  localparam logic [20:0] CH_LBRACE = 21'h7B;
  localparam logic [20:0] CH_RBRACE = 21'h7D;
  localparam logic [20:0] CH_A      = 21'h61;
  localparam logic [20:0] CH_E      = 21'h65;
  localparam logic [20:0] CH_F      = 21'h66;
  localparam logic [20:0] CH_L      = 21'h6C;
  localparam logic [20:0] CH_N      = 21'h6E;
  localparam logic [20:0] CH_R      = 21'h72;
  localparam logic [20:0] CH_S      = 21'h73;
  localparam logic [20:0] CH_T      = 21'h74;
  localparam logic [20:0] CH_U      = 21'h75;

  typedef struct packed {
    logic        mode;
    logic [20:0] code_point;
  } scan_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [20:0] char_out;
    logic [15:0] string_length;
  } token_item_t;

  // Expected letter of a literal tail at a position
  typedef struct packed {
    logic        avail;
    logic        last;
    logic [20:0] ch;
  } lit_expect_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic lit_expect_t lit_expect(scan_mode_t m, logic [1:0] p);
    lit_expect_t e;
    e = '{avail: 1'b0, last: 1'b0, ch: '0};
    case (m)
      SCAN_NULL: begin
        case (p)
          2'd0: e = '{avail: 1'b1, last: 1'b0, ch: CH_U};
          2'd1: e = '{avail: 1'b1, last: 1'b0, ch: CH_L};
          2'd2: e = '{avail: 1'b1, last: 1'b1, ch: CH_L};
          default: e = '{avail: 1'b0, last: 1'b0, ch: '0};
        endcase
      end
      SCAN_TRUE: begin
        case (p)
          2'd0: e = '{avail: 1'b1, last: 1'b0, ch: CH_R};
          2'd1: e = '{avail: 1'b1, last: 1'b0, ch: CH_U};
          2'd2: e = '{avail: 1'b1, last: 1'b1, ch: CH_E};
          default: e = '{avail: 1'b0, last: 1'b0, ch: '0};
        endcase
      end
      SCAN_FALSE: begin
        case (p)
          2'd0: e = '{avail: 1'b1, last: 1'b0, ch: CH_A};
          2'd1: e = '{avail: 1'b1, last: 1'b0, ch: CH_L};
          2'd2: e = '{avail: 1'b1, last: 1'b0, ch: CH_S};
          default: e = '{avail: 1'b1, last: 1'b1, ch: CH_E};
        endcase
      end
      default: e = '{avail: 1'b0, last: 1'b0, ch: '0};
    endcase
    return e;
  endfunction

endpackage

@@ design/jts_scan.sv @@
module jts_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  jts_pkg::scan_item_t  item,
  output logic                 res_valid,
  output jts_pkg::token_item_t res
);

  jts_pkg::scan_mode_t  scan_mode, scan_mode_next;
  logic [1:0]           literal_position, literal_position_next;
  logic [15:0]          string_count, string_count_next;
  jts_pkg::lit_expect_t exp_ch;
  logic                 lit_match;
  logic [20:0]          c;

  assign c         = item.code_point;
  assign exp_ch    = jts_pkg::lit_expect(scan_mode, literal_position);
  assign lit_match = exp_ch.avail && (c == exp_ch.ch);

  // Next state
  always_comb begin
    scan_mode_next        = scan_mode;
    literal_position_next = literal_position;
    string_count_next     = string_count;
    if (fire && item.mode == jts_pkg::MODE_CHAR) begin
      case (scan_mode)
        jts_pkg::SCAN_NULL, jts_pkg::SCAN_TRUE, jts_pkg::SCAN_FALSE: begin
          if (lit_match) begin
            if (exp_ch.last) begin
              scan_mode_next        = jts_pkg::SCAN_IDLE;
              literal_position_next = 2'd0;
            end else begin
              literal_position_next = literal_position + 2'd1;
            end
          end
        end
        jts_pkg::SCAN_STRING: begin
          if (c == jts_pkg::CH_QUOTE) begin
            scan_mode_next    = jts_pkg::SCAN_IDLE;
            string_count_next = '0;
          end else if (string_count < jts_pkg::MAX_STRING_LEN) begin
            string_count_next = string_count + 16'd1;
          end
        end
        default: begin
          if (c == jts_pkg::CH_QUOTE) begin
            scan_mode_next    = jts_pkg::SCAN_STRING;
            string_count_next = '0;
          end else if (c == jts_pkg::CH_N) begin
            scan_mode_next        = jts_pkg::SCAN_NULL;
            literal_position_next = 2'd0;
          end else if (c == jts_pkg::CH_T) begin
            scan_mode_next        = jts_pkg::SCAN_TRUE;
            literal_position_next = 2'd0;
          end else if (c == jts_pkg::CH_F) begin
            scan_mode_next        = jts_pkg::SCAN_FALSE;
            literal_position_next = 2'd0;
          end
        end
      endcase
    end
  end

  // Result for the current item
  always_comb begin
    res_valid = 1'b0;
    res       = '{token_kind: jts_pkg::K_ERROR, char_out: '0, string_length: '0};
    if (item.mode == jts_pkg::MODE_FLUSH) begin
      res_valid = 1'b1;
      case (scan_mode)
        jts_pkg::SCAN_NULL, jts_pkg::SCAN_TRUE, jts_pkg::SCAN_FALSE,
        jts_pkg::SCAN_STRING: res.token_kind = jts_pkg::K_ERROR;
        default:              res.token_kind = jts_pkg::K_FLUSH_OK;
      endcase
    end else begin
      case (scan_mode)
        jts_pkg::SCAN_NULL, jts_pkg::SCAN_TRUE, jts_pkg::SCAN_FALSE: begin
          if (!lit_match) begin
            res_valid = 1'b1;
          end else if (exp_ch.last) begin
            res_valid = 1'b1;
            case (scan_mode)
              jts_pkg::SCAN_NULL: res.token_kind = jts_pkg::K_NULL;
              jts_pkg::SCAN_TRUE: res.token_kind = jts_pkg::K_TRUE;
              default:            res.token_kind = jts_pkg::K_FALSE;
            endcase
          end
        end
        jts_pkg::SCAN_STRING: begin
          res_valid = 1'b1;
          if (c == jts_pkg::CH_QUOTE) begin
            res.token_kind    = jts_pkg::K_SEND;
            res.string_length = string_count;
          end else begin
            res.token_kind = jts_pkg::K_SCHAR;
            res.char_out   = c;
          end
        end
        default: begin
          // skip whitespace, quote and literal openers
          if (!(c inside {jts_pkg::CH_TAB, jts_pkg::CH_LF, jts_pkg::CH_CR,
                          jts_pkg::CH_SPACE, jts_pkg::CH_QUOTE, jts_pkg::CH_N,
                          jts_pkg::CH_T, jts_pkg::CH_F})) begin
            res_valid = 1'b1;
            case (c)
              jts_pkg::CH_COMMA:  res.token_kind = jts_pkg::K_COMMA;
              jts_pkg::CH_COLON:  res.token_kind = jts_pkg::K_COLON;
              jts_pkg::CH_LBRACK: res.token_kind = jts_pkg::K_LBRACK;
              jts_pkg::CH_RBRACK: res.token_kind = jts_pkg::K_RBRACK;
              jts_pkg::CH_LBRACE: res.token_kind = jts_pkg::K_LBRACE;
              jts_pkg::CH_RBRACE: res.token_kind = jts_pkg::K_RBRACE;
              default:            res.token_kind = jts_pkg::K_ERROR;
            endcase
          end
        end
      endcase
    end
  end

  // Hold scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode        <= jts_pkg::SCAN_IDLE;
      literal_position <= 2'd0;
      string_count     <= '0;
    end else begin
      scan_mode        <= scan_mode_next;
      literal_position <= literal_position_next;
      string_count     <= string_count_next;
    end
  end

endmodule

@@ design/jts_result_fifo.sv @@
module jts_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  jts_pkg::token_item_t  push_item,
  input  logic                  tok_stall,
  output logic                  tok_valid,
  output jts_pkg::token_item_t  tok_item,
  output jts_pkg::fifo_status_t status
);

  jts_pkg::token_item_t slot [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 pop;

  assign tok_valid    = (count != 2'd0);
  assign tok_item     = slot[rd_ptr];
  assign pop          = tok_valid && !tok_stall;
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Store result items
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_item;
  end

endmodule

@@ design/json_token_scanner_top.sv @@
// JSON token scanner: takes one code point item per clock and gives at most one
// token item for it. Whitespace, an opening quote and all letters of null, true
// and false but the last give no token; each string character streams out as a
// string_char token and the closing quote gives string_end with the length,
// saturating at 65535. A flush item gives flush_ok only between tokens, error
// otherwise. Throughput is one item per clock while cp_stall is low; each token
// passes through the input register, then a two-entry result queue. The
// input stalls only while an item waits in the input register and the result
// queue is full, so cp_stall never depends combinationally on tok_stall.
module json_token_scanner_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cp_valid,
  output logic                 cp_stall,
  input  jts_pkg::scan_item_t  cp_item,
  output logic                 tok_valid,
  input  logic                 tok_stall,
  output jts_pkg::token_item_t tok_item
);

  logic                  s1_valid;
  jts_pkg::scan_item_t   s1_item;
  logic                  fire;
  logic                  res_valid;
  jts_pkg::token_item_t  res;
  logic                  push;
  jts_pkg::fifo_status_t fifo_status;

  assign fire     = s1_valid && !fifo_status.full;
  assign cp_stall = s1_valid && fifo_status.full;
  assign push     = fire && res_valid;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cp_valid && !cp_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cp_valid && !cp_stall) s1_item <= cp_item;
  end

  jts_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  jts_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (res),
    .tok_stall (tok_stall),
    .tok_valid (tok_valid),
    .tok_item  (tok_item),
    .status    (fifo_status)
  );

  // Never push into a full result queue
  assert property (@(posedge clk) disable iff (rst) !(push && fifo_status.full))
    else $error("result pushed into full queue");

  // Token kinds stay within the defined set
  assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> (tok_item.token_kind <= jts_pkg::K_FLUSH_OK))
    else $error("undefined token kind");

  // Only string_char carries a code point, only string_end a length
  assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_item.token_kind != jts_pkg::K_SCHAR) |-> (tok_item.char_out == '0))
    else $error("char_out set on non-character token");

  assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_item.token_kind != jts_pkg::K_SEND) |-> (tok_item.string_length == '0))
    else $error("string_length set on non-end token");

endmodule

@@ tb/tb_json_token_scanner_top.sv @@
`timescale 1ns / 100ps

module tb_json_token_scanner_top;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cp_valid = 1'b0;
  logic                 cp_stall;
  jts_pkg::scan_item_t  cp_item = '0;
  logic                 tok_valid;
  logic                 tok_stall = 1'b0;
  jts_pkg::token_item_t tok_item;

  json_token_scanner_top dut (
    .clk       (clk),
    .rst       (rst),
    .cp_valid  (cp_valid),
    .cp_stall  (cp_stall),
    .cp_item   (cp_item),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_item  (tok_item)
  );

  always #5 clk = ~clk;

  // Items waiting to be offered, and tokens the scanner owes us
  jts_pkg::scan_item_t  char_feed[$];
  jts_pkg::token_item_t expected_tokens[$];

  // Shadow scanner state
  jts_pkg::scan_mode_t scan_state = jts_pkg::SCAN_IDLE;
  logic [1:0]          lit_index = '0;
  logic [15:0]         str_len = '0;

  int   accepted_chars = 0;
  int   fail_count = 0;
  int   rand_start = 0;
  int   hold_cnt = 0;
  logic hold_done = 1'b0;
  logic cp_fire = 1'b0;
  logic calm;

  // No idling on either side for a stretch of 100 accepted items mid-run
  assign calm = (accepted_chars >= 200) && (accepted_chars < 300);

  // Work out the token (if any) that one accepted item produces
  task automatic scan_predict(input jts_pkg::scan_item_t it);
    jts_pkg::token_item_t tk;
    logic                 emits;
    string                tail;
    logic [3:0]           lit_kind;
    tk = '0;
    emits = 1'b1;
    tail = "";
    lit_kind = jts_pkg::K_NULL;
    if (it.mode == jts_pkg::MODE_FLUSH) begin
      tk.token_kind = (scan_state == jts_pkg::SCAN_IDLE) ? jts_pkg::K_FLUSH_OK
                                                         : jts_pkg::K_ERROR;
    end else begin
      case (scan_state)
        jts_pkg::SCAN_NULL, jts_pkg::SCAN_TRUE, jts_pkg::SCAN_FALSE: begin
          case (scan_state)
            jts_pkg::SCAN_NULL: begin
              tail = "ull";
              lit_kind = jts_pkg::K_NULL;
            end
            jts_pkg::SCAN_TRUE: begin
              tail = "rue";
              lit_kind = jts_pkg::K_TRUE;
            end
            default: begin
              tail = "alse";
              lit_kind = jts_pkg::K_FALSE;
            end
          endcase
          if (lit_index >= tail.len() || it.code_point != 21'(tail[lit_index])) begin
            tk.token_kind = jts_pkg::K_ERROR;
          end else if (lit_index == tail.len() - 1) begin
            tk.token_kind = lit_kind;
            scan_state = jts_pkg::SCAN_IDLE;
            lit_index = '0;
          end else begin
            lit_index = lit_index + 2'd1;
            emits = 1'b0;
          end
        end
        jts_pkg::SCAN_STRING: begin
          if (it.code_point == jts_pkg::CH_QUOTE) begin
            tk.token_kind = jts_pkg::K_SEND;
            tk.string_length = str_len;
            scan_state = jts_pkg::SCAN_IDLE;
            str_len = '0;
          end else begin
            if (str_len != jts_pkg::MAX_STRING_LEN) str_len = str_len + 16'd1;
            tk.token_kind = jts_pkg::K_SCHAR;
            tk.char_out = it.code_point;
          end
        end
        default: begin
          case (it.code_point)
            jts_pkg::CH_TAB, jts_pkg::CH_LF, jts_pkg::CH_CR,
            jts_pkg::CH_SPACE: emits = 1'b0;
            jts_pkg::CH_QUOTE: begin
              scan_state = jts_pkg::SCAN_STRING;
              str_len = '0;
              emits = 1'b0;
            end
            jts_pkg::CH_N: begin
              scan_state = jts_pkg::SCAN_NULL;
              lit_index = '0;
              emits = 1'b0;
            end
            jts_pkg::CH_T: begin
              scan_state = jts_pkg::SCAN_TRUE;
              lit_index = '0;
              emits = 1'b0;
            end
            jts_pkg::CH_F: begin
              scan_state = jts_pkg::SCAN_FALSE;
              lit_index = '0;
              emits = 1'b0;
            end
            jts_pkg::CH_COMMA:  tk.token_kind = jts_pkg::K_COMMA;
            jts_pkg::CH_COLON:  tk.token_kind = jts_pkg::K_COLON;
            jts_pkg::CH_LBRACK: tk.token_kind = jts_pkg::K_LBRACK;
            jts_pkg::CH_RBRACK: tk.token_kind = jts_pkg::K_RBRACK;
            jts_pkg::CH_LBRACE: tk.token_kind = jts_pkg::K_LBRACE;
            jts_pkg::CH_RBRACE: tk.token_kind = jts_pkg::K_RBRACE;
            default:            tk.token_kind = jts_pkg::K_ERROR;
          endcase
        end
      endcase
    end
    if (emits) expected_tokens.push_back(tk);
  endtask

  // Stimulus helpers
  task automatic push_char(input logic [20:0] c);
    char_feed.push_back('{mode: jts_pkg::MODE_CHAR, code_point: c});
  endtask

  task automatic push_flush();
    char_feed.push_back('{mode: jts_pkg::MODE_FLUSH,
                          code_point: 21'($urandom_range(1114111))});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(21'(s[i]));
  endtask

  // Any code point but the closing quote; half of them plain ASCII
  function automatic logic [20:0] string_char();
    logic [20:0] c;
    if ($urandom_range(1)) c = 21'($urandom_range(16'h7E, 16'h20));
    else c = 21'($urandom_range(1114111));
    if (c == jts_pkg::CH_QUOTE) c = jts_pkg::CH_A;
    return c;
  endfunction

  function automatic logic [20:0] digit_char();
    return 21'(8'h30 + $urandom_range(9));
  endfunction

  // Accept side: predict, then check tokens against the oldest expectation
  always @(posedge clk) begin
    jts_pkg::token_item_t exp_tok;
    cp_fire <= !rst && cp_valid && !cp_stall;
    if (!rst) begin
      if (cp_valid && !cp_stall) begin
        scan_predict(cp_item);
        accepted_chars++;
      end
      if (tok_valid && !tok_stall) begin
        if (expected_tokens.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected token: expected none, got kind %0d char %h len %0d",
                   $time, tok_item.token_kind, tok_item.char_out, tok_item.string_length);
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (tok_item.token_kind !== exp_tok.token_kind ||
              tok_item.char_out !== exp_tok.char_out ||
              tok_item.string_length !== exp_tok.string_length) begin
            fail_count++;
            $display("%0t: mismatch: expected kind %0d char %h len %0d",
                     $time, exp_tok.token_kind, exp_tok.char_out,
                     exp_tok.string_length,
                     ", got kind %0d char %h len %0d",
                     tok_item.token_kind, tok_item.char_out, tok_item.string_length);
          end
        end
      end
    end
  end

  // Sender: advance once the offered item is taken, idle at random
  always @(negedge clk) begin
    if (!rst && (!cp_valid || cp_fire)) begin
      if (char_feed.size() != 0 && (calm || hold_cnt != 0 || $urandom_range(99) >= 25)) begin
        cp_item <= char_feed.pop_front();
        cp_valid <= 1'b1;
      end else begin
        cp_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the scanner up
  always @(negedge clk) begin
    if (rst) begin
      tok_stall <= 1'b0;
    end else if (!hold_done && rand_start != 0 && accepted_chars >= rand_start + 50) begin
      hold_done <= 1'b1;
      hold_cnt <= 40;
      tok_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      tok_stall <= 1'b1;
    end else begin
      tok_stall <= !calm && ($urandom_range(99) < 25);
    end
  end

  initial begin
    int    sent;
    int    pick;
    int    k;
    string word;
    string punct;
    string blanks;

    punct = ",:[]{}";
    blanks = "\t\n\r ";

    // Directed: extremes, every token, errors in idle, true, false and string modes, flush cases
    char_feed.push_back('{mode: jts_pkg::MODE_FLUSH, code_point: 21'h10FFFF});
    push_char(jts_pkg::CH_TAB);
    push_char(jts_pkg::CH_LF);
    push_char(jts_pkg::CH_CR);
    push_char(jts_pkg::CH_SPACE);
    push_text(",:[]{}");
    push_char(digit_char());
    push_text("null");
    push_text("tx");
    push_text("rue");
    push_char(jts_pkg::CH_F);
    push_flush();
    push_text("alse");
    push_char(jts_pkg::CH_QUOTE);
    push_char(21'h0);
    push_char(21'h10FFFF);
    push_flush();
    push_char(jts_pkg::CH_QUOTE);
    push_text("\"\"");
    rand_start = char_feed.size();

    // Random: mostly well-formed tokens with random content, some noise
    sent = 0;
    while (sent < 360) begin
      pick = $urandom_range(99);
      case ($urandom_range(2))
        0: word = "null";
        1: word = "true";
        default: word = "false";
      endcase
      if (pick < 20) begin
        push_char(21'(punct[$urandom_range(5)]));
        sent += 1;
      end else if (pick < 28) begin
        push_char(21'(blanks[$urandom_range(3)]));
      end else if (pick < 45) begin
        push_text(word);
        sent += word.len();
      end else if (pick < 72) begin
        k = $urandom_range(8);
        push_char(jts_pkg::CH_QUOTE);
        for (int i = 0; i < k; i++) push_char(string_char());
        push_char(jts_pkg::CH_QUOTE);
        sent += k + 2;
      end else if (pick < 80) begin
        push_flush();
        sent += 1;
      end else if (pick < 88) begin
        // break a literal midway, then finish it
        k = $urandom_range(word.len() - 1, 1);
        for (int i = 0; i < k; i++) push_char(21'(word[i]));
        if ($urandom_range(1)) push_flush();
        else push_char(digit_char());
        for (int i = k; i < word.len(); i++) push_char(21'(word[i]));
        sent += word.len() + 1;
      end else if (pick < 95) begin
        k = $urandom_range(1114111);
        if (k == jts_pkg::CH_QUOTE || k == jts_pkg::CH_N ||
            k == jts_pkg::CH_T || k == jts_pkg::CH_F) push_char(digit_char());
        else push_char(21'(k));
        sent += 1;
      end else begin
        // flush inside an open string
        push_char(jts_pkg::CH_QUOTE);
        push_char(string_char());
        push_flush();
        push_char(string_char());
        push_char(jts_pkg::CH_QUOTE);
        sent += 5;
      end
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Drain: all items taken, all tokens seen, then a settling wait
    while (char_feed.size() != 0 || cp_valid) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_tokens.size() != 0) begin
      fail_count += expected_tokens.size();
      $display("%0t: %0d expected tokens never arrived", $time, expected_tokens.size());
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/jts_pkg.sv
design/jts_scan.sv
design/jts_result_fifo.sv
design/json_token_scanner_top.sv
tb/tb_json_token_scanner_top.sv
